// ----- design/assert_macros.svh -----
// Assertion helpers used by the decompressor unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LZ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define LZ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/lzfwd_pkg.sv -----
`default_nettype none
package lzfwd_pkg;

    localparam int KEY_LEN_W  = 10;
    localparam int OUT_LEN_W  = 24;
    localparam int CFG_DATA_W = 24;

    localparam logic [9:0]  KEY_LEN_RESET = 10'd299;
    localparam logic [23:0] OUT_LEN_RESET = 24'd1;
    localparam logic [23:0] COUNT_MAX     = 24'hFFFFFF;

    // Configuration register indexes.
    localparam logic CFG_KEY_LENGTH    = 1'b0;
    localparam logic CFG_OUTPUT_LENGTH = 1'b1;

    // Request kinds on the input stream.
    localparam logic OP_KEY    = 1'b0;
    localparam logic OP_PACKED = 1'b1;

    // Decoder phases.
    localparam logic [1:0] PH_FLAGS  = 2'd0;
    localparam logic [1:0] PH_TOKEN  = 2'd1;
    localparam logic [1:0] PH_MATCH2 = 2'd2;

    localparam logic [4:0]  TOKENS_PER_GROUP = 5'd30;
    localparam logic [13:0] DIST_MASK        = 14'h3fff;
    localparam logic [5:0]  MATCH_MIN_LEN    = 6'd3;
    localparam logic [1:0]  HDR_LAST         = 2'd3;

    typedef struct packed {
        logic       load;
        logic       step;
        logic [7:0] data;
    } t_key_req;

endpackage
`default_nettype wire

// ----- design/lzfwd_ram.sv -----
`default_nettype none
module lzfwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // The read data holds until the next read.
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- design/lzfwd_key_unit.sv -----
`default_nettype none
module lzfwd_key_unit #(
    parameter int KEY_DEPTH = 512
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire lzfwd_pkg::t_key_req     i_req,
    input  wire [lzfwd_pkg::KEY_LEN_W-1:0] i_key_length,
    output logic [7:0]                   o_key_byte
);
    import lzfwd_pkg::*;

    localparam int KAW = $clog2(KEY_DEPTH);
    localparam int CW  = (KAW + 1 > KEY_LEN_W) ? KAW + 1 : KEY_LEN_W;

    logic [KAW-1:0] r_load_idx, n_load_idx;
    logic [KAW-1:0] r_read_idx, n_read_idx;
    logic [CW-1:0]  len_c;
    logic [CW-1:0]  read_inc;

    // Effective key length: zero acts as one, and it never exceeds the store.
    always_comb begin
        len_c = CW'(i_key_length);
        if (len_c == '0) begin
            len_c = CW'(1);
        end else if (len_c > CW'(KEY_DEPTH)) begin
            len_c = CW'(KEY_DEPTH);
        end
    end

    always_comb begin
        n_load_idx = r_load_idx;
        n_read_idx = r_read_idx;
        read_inc   = CW'(r_read_idx) + CW'(1);
        if (i_req.load) begin
            n_load_idx = (r_load_idx == KAW'(KEY_DEPTH - 1)) ? '0 : r_load_idx + KAW'(1);
        end
        if (i_req.step) begin
            n_read_idx = (read_inc >= len_c) ? '0 : read_inc[KAW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_idx <= '0;
            r_read_idx <= '0;
        end else begin
            r_load_idx <= n_load_idx;
            r_read_idx <= n_read_idx;
        end
    end

    lzfwd_ram #(
        .WIDTH (8),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.load),
        .i_waddr (r_load_idx),
        .i_wdata (i_req.data),
        .i_re    (i_req.step),
        .i_raddr (r_read_idx),
        .o_rdata (o_key_byte)
    );

endmodule
`default_nettype wire

// ----- design/lz_flag_word_decompressor_unit.sv -----
// Key requests are taken in the idle state; a packed byte is accepted, then descrambled
// and decoded, or dropped on acceptance once decoding has finished. A literal reaches the
// output register from S_PROC once that register is free. A match's second byte leads to
// setup, a read ahead, then one byte per cycle from the window memory when not stalled.
// Synchronous active-low reset clears all control state; the key store and the
// history window are not cleared and hold garbage until written.
`default_nettype none
`include "assert_macros.svh"
module lz_flag_word_decompressor_unit #(
    parameter int WINDOW_SIZE = 16384,
    parameter int KEY_DEPTH   = 512
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // Configuration write port.
    input  wire                            i_cfg_we,
    input  wire                            i_cfg_index,
    input  wire [lzfwd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input stream.
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire [7:0]                      s_axis_tdata,   // [7:0] data_byte
    input  wire                            s_axis_tuser,   // [0] op
    // Output stream.
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    output logic [7:0]                     m_axis_tdata,   // [7:0] out_byte
    output logic                           m_axis_tlast,   // last_of_run
    output logic                           m_axis_tuser    // [0] end_of_output
);
    import lzfwd_pkg::*;

    localparam int WAW = $clog2(WINDOW_SIZE);

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROC  = 2'd1;
    localparam logic [1:0] S_SETUP = 2'd2;
    localparam logic [1:0] S_COPY  = 2'd3;

    // Configuration registers.
    logic [KEY_LEN_W-1:0] r_key_len;
    logic [OUT_LEN_W-1:0] r_out_len;

    // Decoder control state.
    logic [1:0]           r_state,    n_state;
    logic [1:0]           r_phase,    n_phase;
    logic [31:0]          r_flag,     n_flag;
    logic [4:0]           r_tok,      n_tok;
    logic [1:0]           r_hdr,      n_hdr;
    logic [1:0]           r_mode,     n_mode;
    logic [OUT_LEN_W-1:0] r_produced, n_produced;
    logic                 r_finished, n_finished;
    logic [WAW-1:0]       r_wp,       n_wp;

    // Match copy engine.
    logic [WAW-1:0]       r_src,      n_src;
    logic [5:0]           r_cnt,      n_cnt;
    logic [5:0]           r_rd_left,  n_rd_left;
    logic [5:0]           r_em_left,  n_em_left;
    logic                 r_rd_pend,  n_rd_pend;
    logic                 r_fwd,      n_fwd;
    logic [7:0]           r_fwd_data, n_fwd_data;

    // Payload holding registers.
    logic [7:0]           r_in_data,  n_in_data;
    logic [7:0]           r_first,    n_first;
    logic [15:0]          r_mw,       n_mw;

    // Output register.
    logic                 r_m_valid,  n_m_valid;
    logic [7:0]           r_m_data,   n_m_data;
    logic                 r_m_last,   n_m_last;
    logic                 r_m_end,    n_m_end;

    t_key_req             key_req;
    logic [7:0]           key_byte;
    logic [7:0]           win_q;

    logic                 s_accept;
    logic                 out_free;
    logic [7:0]           plain;
    logic                 emit;
    logic [7:0]           emit_byte;
    logic                 tok_end;
    logic [5:0]           tok_n;
    logic [OUT_LEN_W:0]   sum_raw;
    logic [OUT_LEN_W-1:0] sum_sat;
    logic                 fin_hit;
    logic                 consume;
    logic                 issue;
    logic [13:0]          off_m1;
    logic [WAW:0]         diff;
    logic [WAW:0]         diff_adj;
    logic                 copy_even;
    logic                 done_quiet;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    assign key_req.load  = s_accept && (s_axis_tuser == OP_KEY);
    assign key_req.step  = s_accept && (s_axis_tuser == OP_PACKED) && !r_finished;
    assign key_req.data  = s_axis_tdata;

    // The descrambled byte is valid in S_PROC: the key memory holds its read data.
    assign plain = r_in_data ^ key_byte;

    // Copy engine handshake: a pending read result moves to the output register when
    // that register frees up, and the next read goes out in the same cycle.
    assign consume = (r_state == S_COPY) && r_rd_pend && out_free;
    assign issue   = (r_state == S_COPY) && (!r_rd_pend || consume) && (r_rd_left != '0);

    // Token length and saturating byte count at the end of a token.
    assign tok_n   = (r_state == S_COPY) ? r_cnt : 6'd1;
    assign sum_raw = {1'b0, r_produced} + (OUT_LEN_W + 1)'(tok_n);
    assign sum_sat = sum_raw[OUT_LEN_W] ? COUNT_MAX : sum_raw[OUT_LEN_W-1:0];
    assign fin_hit = (sum_sat >= r_out_len);

    // Source address of a match: write pointer minus offset, wrapped into the window.
    assign off_m1   = r_mw[13:0] & (DIST_MASK >> r_mode);
    assign diff     = {1'b0, r_wp} - (WAW + 1)'(off_m1) - (WAW + 1)'(1);
    assign diff_adj = diff[WAW] ? diff + (WAW + 1)'(WINDOW_SIZE) : diff;

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_flag     = r_flag;
        n_tok      = r_tok;
        n_hdr      = r_hdr;
        n_mode     = r_mode;
        n_produced = r_produced;
        n_finished = r_finished;
        n_wp       = r_wp;
        n_src      = r_src;
        n_cnt      = r_cnt;
        n_rd_left  = r_rd_left;
        n_em_left  = r_em_left;
        n_rd_pend  = r_rd_pend;
        n_fwd      = r_fwd;
        n_fwd_data = r_fwd_data;
        n_in_data  = r_in_data;
        n_first    = r_first;
        n_mw       = r_mw;
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_data   = r_m_data;
        n_m_last   = r_m_last;
        n_m_end    = r_m_end;
        emit       = 1'b0;
        emit_byte  = plain;
        tok_end    = 1'b0;

        case (r_state)
            S_IDLE: begin
                // Packed bytes after the end of output are dropped here.
                if (key_req.step) begin
                    n_in_data = s_axis_tdata;
                    n_state   = S_PROC;
                end
            end
            S_PROC: begin
                case (r_phase)
                    PH_TOKEN: begin
                        if (r_flag[31]) begin
                            n_first = plain;
                            n_phase = PH_MATCH2;
                            n_state = S_IDLE;
                        end else if (out_free) begin
                            emit     = 1'b1;
                            tok_end  = 1'b1;
                            n_m_last = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                    PH_MATCH2: begin
                        n_mw    = {r_first, plain};
                        n_state = S_SETUP;
                    end
                    default: begin
                        // Flag word header: four bytes, most significant first.
                        n_flag = {r_flag[23:0], plain};
                        if (r_hdr >= HDR_LAST) begin
                            n_hdr   = '0;
                            n_mode  = plain[1:0];
                            n_tok   = TOKENS_PER_GROUP;
                            n_phase = PH_TOKEN;
                        end else begin
                            n_hdr   = r_hdr + 2'd1;
                            n_phase = PH_FLAGS;
                        end
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SETUP: begin
                // Copy length is the word's top bits above the offset field, plus three.
                case (r_mode)
                    2'd0:    n_cnt = 6'(r_mw[15:14]) + MATCH_MIN_LEN;
                    2'd1:    n_cnt = 6'(r_mw[15:13]) + MATCH_MIN_LEN;
                    2'd2:    n_cnt = 6'(r_mw[15:12]) + MATCH_MIN_LEN;
                    default: n_cnt = 6'(r_mw[15:11]) + MATCH_MIN_LEN;
                endcase
                n_rd_left = n_cnt;
                n_em_left = n_cnt;
                n_rd_pend = 1'b0;
                n_fwd     = 1'b0;
                n_src     = diff_adj[WAW-1:0];
                n_state   = S_COPY;
            end
            default: begin
                emit_byte = r_fwd ? r_fwd_data : win_q;
                if (consume) begin
                    emit      = 1'b1;
                    n_em_left = r_em_left - 6'd1;
                    n_m_last  = (r_em_left == 6'd1);
                    if (r_em_left == 6'd1) begin
                        tok_end = 1'b1;
                        n_state = S_IDLE;
                    end
                end
                if (issue) begin
                    n_src     = (r_src == WAW'(WINDOW_SIZE - 1)) ? '0 : r_src + WAW'(1);
                    n_rd_left = r_rd_left - 6'd1;
                    // A read of the entry written in this cycle takes the new byte.
                    n_fwd      = consume && (r_src == r_wp);
                    n_fwd_data = emit_byte;
                end
                n_rd_pend = issue || (r_rd_pend && !consume);
            end
        endcase

        if (emit) begin
            n_m_valid = 1'b1;
            n_m_data  = emit_byte;
            n_m_end   = tok_end && fin_hit;
            n_wp      = (r_wp == WAW'(WINDOW_SIZE - 1)) ? '0 : r_wp + WAW'(1);
        end

        if (tok_end) begin
            n_produced = sum_sat;
            n_tok      = (r_tok != '0) ? r_tok - 5'd1 : '0;
            if (fin_hit) begin
                n_finished = 1'b1;
            end else begin
                n_flag  = {r_flag[30:0], 1'b0};
                n_phase = (n_tok == '0) ? PH_FLAGS : PH_TOKEN;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len  <= KEY_LEN_RESET;
            r_out_len  <= OUT_LEN_RESET;
            r_state    <= S_IDLE;
            r_phase    <= PH_FLAGS;
            r_flag     <= '0;
            r_tok      <= '0;
            r_hdr      <= '0;
            r_mode     <= '0;
            r_produced <= '0;
            r_finished <= 1'b0;
            r_wp       <= '0;
            r_rd_left  <= '0;
            r_em_left  <= '0;
            r_rd_pend  <= 1'b0;
            r_fwd      <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_KEY_LENGTH)) begin
                r_key_len <= i_cfg_data[KEY_LEN_W-1:0];
            end
            if (i_cfg_we && (i_cfg_index == CFG_OUTPUT_LENGTH)) begin
                r_out_len <= i_cfg_data[OUT_LEN_W-1:0];
            end
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_flag     <= n_flag;
            r_tok      <= n_tok;
            r_hdr      <= n_hdr;
            r_mode     <= n_mode;
            r_produced <= n_produced;
            r_finished <= n_finished;
            r_wp       <= n_wp;
            r_rd_left  <= n_rd_left;
            r_em_left  <= n_em_left;
            r_rd_pend  <= n_rd_pend;
            r_fwd      <= n_fwd;
            r_m_valid  <= n_m_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_cnt      <= n_cnt;
        r_fwd_data <= n_fwd_data;
        r_in_data  <= n_in_data;
        r_first    <= n_first;
        r_mw       <= n_mw;
        r_m_data   <= n_m_data;
        r_m_last   <= n_m_last;
        r_m_end    <= n_m_end;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tuser  = r_m_end;

    lzfwd_key_unit #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_key (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (key_req),
        .i_key_length (r_key_len),
        .o_key_byte   (key_byte)
    );

    lzfwd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_SIZE)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (emit),
        .i_waddr (r_wp),
        .i_wdata (emit_byte),
        .i_re    (issue),
        .i_raddr (r_src),
        .o_rdata (win_q)
    );

    // Bytes still to emit equal reads still to issue plus a read in flight.
    assign copy_even  = (r_em_left == r_rd_left + 6'(r_rd_pend));
    // Once the output is complete nothing more is emitted or copied.
    assign done_quiet = r_finished && !emit && (r_state != S_COPY);

    // A decoded byte never overwrites a result that is still waiting.
    `LZ_ASSERT(a_emit_room, i_clk, i_rst_n, !emit || out_free, "emit into full output")
    `LZ_ASSERT(a_copy_balance, i_clk, i_rst_n, (r_state != S_COPY) || copy_even, "copy skew")
    `LZ_ASSERT_NEXT(a_done_quiet, i_clk, i_rst_n, r_finished, done_quiet, "late activity")

endmodule
`default_nettype wire
